### rtl/lz4d_pkg.sv
// ----------------------------------------------------------------------------
// LZ4 decompressor package
// Shared constants and types for the LZ4 block decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lz4d_pkg;

  localparam int HistDepth = 4096;
  localparam int HistAw    = $clog2(HistDepth);
  localparam int LenW      = 13;
  localparam int OutBytes  = 64;
  localparam int CntW      = 7;
  localparam logic [LenW-1:0] LenMax = 13'd8191;
  localparam logic [LenW:0] CapMax =
      (HistDepth < 4096) ? (LenW+1)'(HistDepth) : (LenW+1)'(4096);

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LITEXT, PH_LITERAL, PH_OFFLO, PH_OFFHI, PH_MATCHEXT, PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // Command handed from the parser to the copy engine.
  typedef enum logic [1:0] {
    CMD_LIT, CMD_MATCH, CMD_DONE, CMD_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [7:0]      lit;
    logic            with_lit;
    logic [LenW-1:0] len;
    logic [15:0]     offset;
    logic [LenW-1:0] total;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_READ, BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

### rtl/lz4d_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for compressed input and decompressed results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lz4d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lz4d_out_if;
  logic [63:0] out_lane0;
  logic [63:0] out_lane1;
  logic [63:0] out_lane2;
  logic [63:0] out_lane3;
  logic [63:0] out_lane4;
  logic [63:0] out_lane5;
  logic [63:0] out_lane6;
  logic [63:0] out_lane7;
  logic [6:0]  byte_count;
  logic [1:0]  status;
  logic [12:0] total_length;
  logic        run_last;
  logic        valid;
  logic        ready;
  modport source (output valid, output out_lane0, output out_lane1, output out_lane2,
                  output out_lane3, output out_lane4, output out_lane5, output out_lane6,
                  output out_lane7, output byte_count, output status,
                  output total_length, output run_last, input ready);
  modport sink   (input valid, input out_lane0, input out_lane1, input out_lane2,
                  input out_lane3, input out_lane4, input out_lane5, input out_lane6,
                  input out_lane7, input byte_count, input status,
                  input total_length, input run_last, output ready);
endinterface

`default_nettype wire

### rtl/lz4_block_decompressor.sv
// ----------------------------------------------------------------------------
// LZ4 block decompressor
// Parses an LZ4 block one byte at a time and emits decompressed results.
// ----------------------------------------------------------------------------
//   Channel   Dir  Payload
//   src       in   in_byte, in_last
//   dst       out  out_lane0..7, byte_count, status, total_length, run_last
//   cfg       in   cfg_we, cfg_data (output_capacity)
//
// The parser takes one compressed byte per cycle when no command is pending.
// The copy engine turns a literal or status command into one result and reads
// a match from the history memory one byte at a time, packing it into results
// of up to 64 bytes. Reset is synchronous and clears all control state;
// history content is undefined until written.
// A one-entry command register decouples the parser from the copy engine.
`default_nettype none

module lz4_block_decompressor (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [12:0]   cfg_data,
  lz4d_in_if.sink            src,
  lz4d_out_if.source         dst
);

  logic [lz4d_pkg::LenW-1:0] output_capacity;
  logic                      cmd_valid;
  logic                      cmd_ready;
  lz4d_pkg::cmd_t            cmd;

  // The capacity register is to be written only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= lz4d_pkg::LenW'(4096);
    end else if (cfg_we) begin
      output_capacity <= cfg_data;
    end
  end

  lz4d_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .output_capacity (output_capacity),
    .in_valid        (src.valid),
    .in_ready        (src.ready),
    .in_byte         (src.in_byte),
    .in_last         (src.in_last),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd)
  );

  lz4d_copier u_copier (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res       (dst)
  );

endmodule

`default_nettype wire

### rtl/lz4d_parser.sv
// ----------------------------------------------------------------------------
// LZ4 sequence parser
// Walks the block format one byte per cycle while no command is pending and issues copy commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4d_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [lz4d_pkg::LenW-1:0]     output_capacity,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_last,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output lz4d_pkg::cmd_t                     cmd
);

  lz4d_pkg::phase_t           phase, phase_next;
  logic [3:0]                 match_nibble, match_nibble_next;
  logic [lz4d_pkg::LenW-1:0]  literal_remaining, literal_remaining_next;
  logic [lz4d_pkg::LenW-1:0]  match_length, match_length_next;
  logic [15:0]                offset_value, offset_value_next;
  logic [lz4d_pkg::LenW-1:0]  produced_count, produced_count_next;

  logic [lz4d_pkg::LenW:0]    cap;
  logic [lz4d_pkg::LenW:0]    lit_sum, mat_sum, ext_sum;
  logic [lz4d_pkg::LenW-1:0]  lit_sat, mat_sat;
  logic [15:0]                off_full;
  logic [lz4d_pkg::LenW-1:0]  mat_base;
  logic                       issue;
  lz4d_pkg::cmd_t             c;
  logic                       end_blk;

  assign cap = ({1'b0, output_capacity} > lz4d_pkg::CapMax) ? lz4d_pkg::CapMax
                                                          : {1'b0, output_capacity};
  assign ext_sum  = {1'b0, literal_remaining} + {6'd0, in_byte};
  assign lit_sat  = (ext_sum > {1'b0, lz4d_pkg::LenMax}) ? lz4d_pkg::LenMax
                                                       : ext_sum[lz4d_pkg::LenW-1:0];
  assign mat_sum  = {1'b0, match_length} + {6'd0, in_byte};
  assign mat_sat  = (mat_sum > {1'b0, lz4d_pkg::LenMax}) ? lz4d_pkg::LenMax
                                                       : mat_sum[lz4d_pkg::LenW-1:0];
  assign off_full = {in_byte, offset_value[7:0]};
  assign mat_base = lz4d_pkg::LenW'(match_nibble) + lz4d_pkg::LenW'(4);

  // A single item issues at most one command; stall only when one is pending.
  assign in_ready  = !cmd_valid || cmd_ready;

  always_comb begin
    phase_next             = phase;
    match_nibble_next      = match_nibble;
    literal_remaining_next = literal_remaining;
    match_length_next      = match_length;
    offset_value_next      = offset_value;
    produced_count_next    = produced_count;
    issue                  = 1'b0;
    end_blk                = 1'b0;
    c                      = '0;
    c.kind                 = lz4d_pkg::CMD_ERROR;
    lit_sum                = '0;
    case (phase)
      lz4d_pkg::PH_TOKEN: begin
        match_nibble_next      = in_byte[3:0];
        literal_remaining_next = lz4d_pkg::LenW'(in_byte[7:4]);
        lit_sum = {1'b0, produced_count} + (lz4d_pkg::LenW+1)'(in_byte[7:4]);
        if (in_byte[7:4] == 4'd15) begin
          if (in_last) begin
            issue = 1'b1; end_blk = 1'b1;
          end else begin
            phase_next = lz4d_pkg::PH_LITEXT;
          end
        end else if (in_byte[7:4] == 4'd0) begin
          if (in_last) begin
            issue = 1'b1; c.kind = lz4d_pkg::CMD_DONE; c.total = produced_count;
            end_blk = 1'b1;
          end else begin
            phase_next = lz4d_pkg::PH_OFFLO;
          end
        end else if (lit_sum > cap || in_last) begin
          issue = 1'b1;
          if (in_last) end_blk = 1'b1; else phase_next = lz4d_pkg::PH_ERROR;
        end else begin
          phase_next = lz4d_pkg::PH_LITERAL;
        end
      end
      lz4d_pkg::PH_LITEXT: begin
        literal_remaining_next = lit_sat;
        lit_sum = {1'b0, produced_count} + {1'b0, lit_sat};
        if (in_byte == 8'd255) begin
          if (in_last) begin
            issue = 1'b1; end_blk = 1'b1;
          end
        end else if (lit_sum > cap || in_last) begin
          issue = 1'b1;
          if (in_last) end_blk = 1'b1; else phase_next = lz4d_pkg::PH_ERROR;
        end else begin
          phase_next = lz4d_pkg::PH_LITERAL;
        end
      end
      lz4d_pkg::PH_LITERAL: begin
        issue = 1'b1;
        if (in_last && literal_remaining != lz4d_pkg::LenW'(1)) begin
          end_blk = 1'b1;
        end else begin
          literal_remaining_next = literal_remaining - lz4d_pkg::LenW'(1);
          produced_count_next    = produced_count + lz4d_pkg::LenW'(1);
          c.lit      = in_byte;
          c.with_lit = 1'b1;
          if (in_last) begin
            c.kind  = lz4d_pkg::CMD_DONE;
            c.total = produced_count + lz4d_pkg::LenW'(1);
            end_blk = 1'b1;
          end else begin
            c.kind = lz4d_pkg::CMD_LIT;
            if (literal_remaining == lz4d_pkg::LenW'(1)) phase_next = lz4d_pkg::PH_OFFLO;
          end
        end
      end
      lz4d_pkg::PH_OFFLO: begin
        if (in_last) begin
          issue = 1'b1; end_blk = 1'b1;
        end else begin
          offset_value_next = {8'd0, in_byte};
          phase_next        = lz4d_pkg::PH_OFFHI;
        end
      end
      lz4d_pkg::PH_OFFHI: begin
        offset_value_next = off_full;
        match_length_next = mat_base;
        if (off_full == 16'd0 || {3'd0, produced_count} < off_full) begin
          issue = 1'b1;
          if (in_last) end_blk = 1'b1; else phase_next = lz4d_pkg::PH_ERROR;
        end else if (match_nibble == 4'd15) begin
          if (in_last) begin
            issue = 1'b1; end_blk = 1'b1;
          end else begin
            phase_next = lz4d_pkg::PH_MATCHEXT;
          end
        end else if (in_last) begin
          issue = 1'b1; end_blk = 1'b1;
        end else begin
          lit_sum = {1'b0, produced_count} + {1'b0, mat_base};
          issue = 1'b1;
          if (lit_sum > cap) begin
            phase_next = lz4d_pkg::PH_ERROR;
          end else begin
            c.kind = lz4d_pkg::CMD_MATCH; c.len = mat_base; c.offset = off_full;
            produced_count_next = lit_sum[lz4d_pkg::LenW-1:0];
            phase_next = lz4d_pkg::PH_TOKEN;
          end
        end
      end
      lz4d_pkg::PH_MATCHEXT: begin
        match_length_next = mat_sat;
        if (in_byte == 8'd255) begin
          if (in_last) begin
            issue = 1'b1; end_blk = 1'b1;
          end
        end else if (in_last) begin
          issue = 1'b1; end_blk = 1'b1;
        end else begin
          lit_sum = {1'b0, produced_count} + {1'b0, mat_sat};
          issue = 1'b1;
          if (lit_sum > cap) begin
            phase_next = lz4d_pkg::PH_ERROR;
          end else begin
            c.kind = lz4d_pkg::CMD_MATCH; c.len = mat_sat; c.offset = offset_value;
            produced_count_next = lit_sum[lz4d_pkg::LenW-1:0];
            phase_next = lz4d_pkg::PH_TOKEN;
          end
        end
      end
      default: begin
        if (in_last) end_blk = 1'b1;
      end
    endcase
    if (end_blk) begin
      phase_next             = lz4d_pkg::PH_TOKEN;
      match_nibble_next      = '0;
      literal_remaining_next = '0;
      match_length_next      = '0;
      offset_value_next      = '0;
      produced_count_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= lz4d_pkg::PH_TOKEN;
      match_nibble      <= '0;
      literal_remaining <= '0;
      match_length      <= '0;
      offset_value      <= '0;
      produced_count    <= '0;
      cmd_valid         <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        phase             <= phase_next;
        match_nibble      <= match_nibble_next;
        literal_remaining <= literal_remaining_next;
        match_length      <= match_length_next;
        offset_value      <= offset_value_next;
        produced_count    <= produced_count_next;
      end
      if (in_valid && in_ready && issue) begin
        cmd_valid <= 1'b1;
        cmd       <= c;
      end else if (cmd_ready) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("pending command changed");
  assert property (@(posedge clk) disable iff (rst)
    phase == lz4d_pkg::PH_ERROR && in_valid && in_ready |=> !($rose(cmd_valid)))
    else $error("command issued while discarding");
  assert property (@(posedge clk) disable iff (rst)
    produced_count <= lz4d_pkg::LenW'(4096))
    else $error("produced count past capacity");

endmodule

`default_nettype wire

### rtl/lz4d_copier.sv
// ----------------------------------------------------------------------------
// LZ4 copy engine
// Writes literals and match bytes to history and packs them into results.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4d_copier (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  output logic              cmd_ready,
  input  wire lz4d_pkg::cmd_t cmd,
  lz4d_out_if.source        res
);

  lz4d_pkg::back_state_t       state, state_next;
  logic [7:0]                  mem [lz4d_pkg::HistDepth];
  logic [lz4d_pkg::HistAw-1:0] wptr;
  logic [lz4d_pkg::HistAw-1:0] rptr;
  logic [lz4d_pkg::LenW-1:0]   left;
  logic [7:0]                  rdata;
  logic [7:0]                  buf_b [lz4d_pkg::OutBytes];
  logic [lz4d_pkg::CntW-1:0]   fill;
  logic                        rd_pend;
  logic [lz4d_pkg::HistAw-1:0] back_off;
  logic                        emit_now;
  logic                        ld;
  logic                        chunk_end;
  logic [511:0]                packed_b;

  assign ld        = state == lz4d_pkg::BK_IDLE && cmd_valid && !res.valid;
  assign cmd_ready = ld;
  // The chunk closes once it is full or the match has no bytes left.
  assign chunk_end = rd_pend && (fill == lz4d_pkg::CntW'(63) || left == '0);
  assign emit_now  = chunk_end;

  always_comb begin
    state_next = state;
    case (state)
      lz4d_pkg::BK_IDLE:
        if (ld && cmd.kind == lz4d_pkg::CMD_MATCH) state_next = lz4d_pkg::BK_READ;
      lz4d_pkg::BK_READ:
        if (chunk_end) state_next = lz4d_pkg::BK_EMIT;
      lz4d_pkg::BK_EMIT:
        if (!res.valid) state_next = (left == '0) ? lz4d_pkg::BK_IDLE : lz4d_pkg::BK_READ;
      default: state_next = lz4d_pkg::BK_IDLE;
    endcase
  end

  assign back_off = cmd.offset[lz4d_pkg::HistAw-1:0];

  // Lane packing of the chunk. The byte arriving this cycle lands at position
  // fill; unused bytes read as zero.
  always_comb begin
    for (int i = 0; i < lz4d_pkg::OutBytes; i++) begin
      if (lz4d_pkg::CntW'(i) < fill)       packed_b[8*i +: 8] = buf_b[i];
      else if (lz4d_pkg::CntW'(i) == fill) packed_b[8*i +: 8] = rdata;
      else                                  packed_b[8*i +: 8] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) mem[wptr] <= rdata;
    else if (ld && cmd.with_lit) mem[wptr] <= cmd.lit;
    rdata <= mem[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lz4d_pkg::BK_IDLE;
      res.valid <= 1'b0;
      wptr      <= '0;
      rd_pend   <= 1'b0;
      fill      <= '0;
      left      <= '0;
    end else begin
      state <= state_next;
      if (res.valid && res.ready) res.valid <= 1'b0;
      rd_pend <= 1'b0;
      if (ld) begin
        case (cmd.kind)
          lz4d_pkg::CMD_MATCH: begin
            rptr <= wptr - back_off;
            left <= cmd.len;
            fill <= '0;
          end
          default: begin
            res.valid        <= 1'b1;
            res.byte_count   <= cmd.with_lit ? lz4d_pkg::CntW'(1) : '0;
            res.out_lane0    <= cmd.with_lit ? {56'd0, cmd.lit} : 64'd0;
            res.out_lane1    <= '0; res.out_lane2 <= '0; res.out_lane3 <= '0;
            res.out_lane4    <= '0; res.out_lane5 <= '0; res.out_lane6 <= '0;
            res.out_lane7    <= '0;
            res.run_last     <= 1'b1;
            res.status       <= (cmd.kind == lz4d_pkg::CMD_DONE) ? lz4d_pkg::ST_DONE :
                                (cmd.kind == lz4d_pkg::CMD_ERROR) ? lz4d_pkg::ST_ERROR :
                                lz4d_pkg::ST_DATA;
            res.total_length <= (cmd.kind == lz4d_pkg::CMD_DONE) ? cmd.total : '0;
            if (cmd.kind == lz4d_pkg::CMD_DONE || cmd.kind == lz4d_pkg::CMD_ERROR) begin
              wptr <= '0;
            end else if (cmd.with_lit) begin
              wptr <= wptr + 1'b1;
            end
          end
        endcase
      end
      if (state == lz4d_pkg::BK_READ && !rd_pend && left != '0) begin
        rd_pend <= 1'b1;
        left    <= left - lz4d_pkg::LenW'(1);
        rptr    <= rptr + 1'b1;
      end
      if (rd_pend) begin
        buf_b[fill[5:0]] <= rdata;
        wptr <= wptr + 1'b1;
        fill <= fill + 1'b1;
      end
      if (emit_now) begin
        res.valid        <= 1'b1;
        res.byte_count   <= fill + 1'b1;
        res.status       <= lz4d_pkg::ST_DATA;
        res.total_length <= '0;
        res.run_last     <= left == '0;
        res.out_lane0    <= packed_b[63:0];
        res.out_lane1    <= packed_b[127:64];
        res.out_lane2    <= packed_b[191:128];
        res.out_lane3    <= packed_b[255:192];
        res.out_lane4    <= packed_b[319:256];
        res.out_lane5    <= packed_b[383:320];
        res.out_lane6    <= packed_b[447:384];
        res.out_lane7    <= packed_b[511:448];
      end
      if (state == lz4d_pkg::BK_EMIT && !res.valid) fill <= '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.byte_count <= lz4d_pkg::CntW'(64))
    else $error("byte count past lane width");
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != lz4d_pkg::ST_DATA |-> res.run_last)
    else $error("status result not final");
  assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == lz4d_pkg::BK_READ)
    else $error("history read outside copy");

endmodule

`default_nettype wire

### tb/lz4_block_decompressor_tb.sv
// ----------------------------------------------------------------------------
// LZ4 block decompressor testbench
// Feeds compressed blocks (well-formed, truncated, corrupted and random noise)
// into the decompressor one byte per transfer. A behavioral decoder in the
// bench predicts every result. A monitor checks each result transfer field by
// field against the oldest prediction. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4_block_decompressor_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 15000000;
  localparam int SettleCycles = 100;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } comp_byte_t;

  // One predicted result transfer. Byte k of the result sits at bits 8k+7:8k.
  typedef struct {
    logic [511:0] bytes;
    logic [6:0]   count;
    logic [1:0]   status;
    logic [12:0]  total;
    logic         run_last;
  } out_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [12:0] cfg_data;

  lz4d_in_if  in_ch ();
  lz4d_out_if out_ch ();

  lz4_block_decompressor u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .src      (in_ch),
    .dst      (out_ch)
  );

  always #5 clk = ~clk;

  // Stimulus and prediction storage.
  comp_byte_t comp_bytes_q[$];
  out_word_t  decoded_q[$];
  comp_byte_t blk_q[$];
  int         bytes_queued = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         calm = 1'b0;
  int         src_gap = 0;
  int         snk_gap = 0;

  // Decoder state mirrored in the bench.
  lz4d_pkg::phase_t dec_phase;
  int unsigned dec_match_nib;
  int unsigned dec_lit_left;
  int unsigned dec_match_len;
  int unsigned dec_offset;
  int unsigned dec_produced;
  int unsigned dec_capacity;
  logic [7:0]  dec_hist [lz4d_pkg::HistDepth];
  out_word_t   step_out[$];

  task automatic report(input string what, input logic [511:0] got, input logic [511:0] want);
    mismatches++;
    $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  function automatic void clear_block();
    dec_phase = lz4d_pkg::PH_TOKEN;
    dec_lit_left = 0;
    dec_match_len = 0;
    dec_match_nib = 0;
    dec_offset = 0;
    dec_produced = 0;
  endfunction

  function automatic int unsigned cap_limit();
    return (dec_capacity > 4096) ? 4096 : dec_capacity;
  endfunction

  function automatic int unsigned sat_len(input int unsigned a, input int unsigned b);
    return (a + b > lz4d_pkg::LenMax) ? lz4d_pkg::LenMax : a + b;
  endfunction

  // Appends one decoded byte to history and packs it into the current result.
  function automatic void emit_byte(input logic [7:0] b);
    out_word_t w;
    int idx;
    if (dec_produced < lz4d_pkg::HistDepth) dec_hist[dec_produced] = b;
    dec_produced++;
    if (step_out.size() == 0 || step_out[step_out.size()-1].count == 7'd64) begin
      w = '{default: '0};
      step_out.push_back(w);
    end
    idx = step_out.size() - 1;
    step_out[idx].bytes[8*step_out[idx].count +: 8] = b;
    step_out[idx].count++;
  endfunction

  // An error throws away everything of this step and sends one empty result.
  function automatic void raise_error(input logic last);
    out_word_t w;
    w = '{default: '0};
    w.status = lz4d_pkg::ST_ERROR;
    step_out.delete();
    step_out.push_back(w);
    if (last) clear_block();
    else dec_phase = lz4d_pkg::PH_ERROR;
  endfunction

  function automatic void finish_ok();
    out_word_t w;
    int idx;
    if (step_out.size() == 0) begin
      w = '{default: '0};
      step_out.push_back(w);
    end
    idx = step_out.size() - 1;
    step_out[idx].status = lz4d_pkg::ST_DONE;
    step_out[idx].total = dec_produced[12:0];
    clear_block();
  endfunction

  function automatic void copy_match(input logic last);
    int unsigned src_pos;
    if (last) begin
      raise_error(1'b1);
      return;
    end
    if (dec_produced + dec_match_len > cap_limit()) begin
      raise_error(1'b0);
      return;
    end
    for (int unsigned i = 0; i < dec_match_len; i++) begin
      src_pos = dec_produced - dec_offset;
      emit_byte((src_pos < lz4d_pkg::HistDepth) ? dec_hist[src_pos] : 8'h00);
    end
    dec_phase = lz4d_pkg::PH_TOKEN;
  endfunction

  function automatic void open_literals(input logic last);
    if (dec_produced + dec_lit_left > cap_limit()) raise_error(last);
    else if (last) raise_error(1'b1);
    else dec_phase = lz4d_pkg::PH_LITERAL;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    case (dec_phase)
      lz4d_pkg::PH_TOKEN: begin
        dec_match_nib = b[3:0];
        dec_lit_left = b[7:4];
        if (dec_lit_left == 15) begin
          if (last) raise_error(1'b1);
          else dec_phase = lz4d_pkg::PH_LITEXT;
        end else if (dec_lit_left == 0) begin
          if (last) finish_ok();
          else dec_phase = lz4d_pkg::PH_OFFLO;
        end else begin
          open_literals(last);
        end
      end
      lz4d_pkg::PH_LITEXT: begin
        dec_lit_left = sat_len(dec_lit_left, b);
        if (b == 8'hFF) begin
          if (last) raise_error(1'b1);
        end else begin
          open_literals(last);
        end
      end
      lz4d_pkg::PH_LITERAL: begin
        if (last && dec_lit_left != 1) begin
          raise_error(1'b1);
        end else begin
          emit_byte(b);
          dec_lit_left--;
          if (last) finish_ok();
          else if (dec_lit_left == 0) dec_phase = lz4d_pkg::PH_OFFLO;
        end
      end
      lz4d_pkg::PH_OFFLO: begin
        if (last) raise_error(1'b1);
        else begin
          dec_offset = b;
          dec_phase = lz4d_pkg::PH_OFFHI;
        end
      end
      lz4d_pkg::PH_OFFHI: begin
        dec_offset = dec_offset | (int'(b) << 8);
        if (dec_offset == 0 || dec_produced < dec_offset) begin
          raise_error(last);
        end else begin
          dec_match_len = dec_match_nib + 4;
          if (dec_match_nib == 15) begin
            if (last) raise_error(1'b1);
            else dec_phase = lz4d_pkg::PH_MATCHEXT;
          end else begin
            copy_match(last);
          end
        end
      end
      lz4d_pkg::PH_MATCHEXT: begin
        dec_match_len = sat_len(dec_match_len, b);
        if (b == 8'hFF) begin
          if (last) raise_error(1'b1);
        end else begin
          copy_match(last);
        end
      end
      default: begin
        // After an error everything is dropped up to the end of the block.
        if (last) clear_block();
      end
    endcase
  endfunction

  // Predicts the results of one accepted byte and queues them in order.
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    step_out.delete();
    decode_byte(b, last);
    if (step_out.size() > 0) step_out[step_out.size()-1].run_last = 1'b1;
    foreach (step_out[i]) decoded_q.push_back(step_out[i]);
  endfunction

  // Source driver: a new byte is offered once the previous one has made its
  // transfer. The byte is predicted at the edge where its transfer happens.
  always @(posedge clk) begin
    comp_byte_t it;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.in_byte <= 8'h00;
      in_ch.in_last <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.in_byte, in_ch.in_last);
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (comp_bytes_q.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
          // Start an idle burst.
          src_gap = $urandom_range(0, 3);
          in_ch.valid <= 1'b0;
        end else if (comp_bytes_q.size() > 0) begin
          it = comp_bytes_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.in_byte <= it.data;
          in_ch.in_last <= it.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: ready drops in random bursts, never in the calm part.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      snk_gap = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: every result transfer is held against the oldest prediction.
  always @(posedge clk) begin
    out_word_t want;
    logic [511:0] got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.out_lane7, out_ch.out_lane6, out_ch.out_lane5, out_ch.out_lane4,
             out_ch.out_lane3, out_ch.out_lane2, out_ch.out_lane1, out_ch.out_lane0};
      if (decoded_q.size() == 0) begin
        report("unexpected result transfer", got, '0);
      end else begin
        want = decoded_q.pop_front();
        for (int j = 0; j < 8; j++) begin
          if (got[64*j +: 64] !== want.bytes[64*j +: 64])
            report($sformatf("out_lane%0d", j), 512'(got[64*j +: 64]),
                   512'(want.bytes[64*j +: 64]));
        end
        if (out_ch.byte_count !== want.count)
          report("byte_count", 512'(out_ch.byte_count), 512'(want.count));
        if (out_ch.status !== want.status)
          report("status", 512'(out_ch.status), 512'(want.status));
        if (out_ch.total_length !== want.total)
          report("total_length", 512'(out_ch.total_length), 512'(want.total));
        if (out_ch.run_last !== want.run_last)
          report("run_last", 512'(out_ch.run_last), 512'(want.run_last));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    comp_byte_t it;
    it.data = b;
    it.last = last;
    blk_q.push_back(it);
  endtask

  // Length extension bytes: runs of 255 and a final byte below 255.
  task automatic push_ext(input int extra);
    while (extra >= 255) begin
      push_byte(8'hFF, 1'b0);
      extra -= 255;
    end
    push_byte(extra[7:0], 1'b0);
  endtask

  task automatic flush_block();
    foreach (blk_q[i]) comp_bytes_q.push_back(blk_q[i]);
    bytes_queued += blk_q.size();
    blk_q.delete();
  endtask

  // Builds a well-formed block: a few sequences with random content and a
  // closing literal-only sequence.
  task automatic build_block();
    int nseq;
    int made;
    int lit;
    int mlen;
    int offs;
    int lnib;
    int mnib;
    nseq = $urandom_range(1, 4);
    made = 0;
    for (int s = 0; s < nseq; s++) begin
      lit = (made == 0) ? $urandom_range(1, 6) : $urandom_range(0, 6);
      if ($urandom_range(0, 7) == 0) lit = $urandom_range(15, 40);
      if ($urandom_range(0, 40) == 0) lit = $urandom_range(255, 300);
      mnib = $urandom_range(0, 14);
      mlen = mnib + 4;
      if ($urandom_range(0, 5) == 0) begin
        mnib = 15;
        mlen = 19 + $urandom_range(0, 60);
      end
      if ($urandom_range(0, 24) == 0) begin
        mnib = 15;
        mlen = 19 + 255 + $urandom_range(0, 300);
      end
      lnib = (lit >= 15) ? 15 : lit;
      push_byte({lnib[3:0], mnib[3:0]}, 1'b0);
      if (lnib == 15) push_ext(lit - 15);
      repeat (lit) push_byte(8'($urandom_range(0, 255)), 1'b0);
      made += lit;
      // Short offsets make overlapping copies that replicate bytes.
      offs = $urandom_range(0, 1) ? $urandom_range(1, (made < 4) ? made : 4)
                                  : $urandom_range(1, made);
      push_byte(offs[7:0], 1'b0);
      push_byte(offs[15:8], 1'b0);
      if (mnib == 15) push_ext(mlen - 19);
      made += mlen;
    end
    lit = $urandom_range(0, 4);
    if (lit == 0) begin
      push_byte({4'h0, 4'($urandom_range(0, 15))}, 1'b1);
    end else begin
      push_byte({lit[3:0], 4'($urandom_range(0, 15))}, 1'b0);
      for (int i = 0; i < lit; i++) push_byte(8'($urandom_range(0, 255)), i == lit - 1);
    end
  endtask

  task automatic random_stretch(input int count);
    int target;
    int pick;
    int cut;
    int n;
    target = bytes_queued + count;
    while (bytes_queued < target) begin
      pick = $urandom_range(0, 9);
      if (pick <= 8) begin
        build_block();
        if (pick == 7) begin
          // Truncate the block at a random byte.
          cut = $urandom_range(0, blk_q.size() - 1);
          while (blk_q.size() > cut + 1) void'(blk_q.pop_back());
          blk_q[cut].last = 1'b1;
        end else if (pick == 8) begin
          // Corrupt one byte, which often gives a bad offset or a bad length.
          cut = $urandom_range(0, blk_q.size() - 1);
          blk_q[cut].data = 8'($urandom_range(0, 255));
        end
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), i == n - 1);
      end
      flush_block();
    end
  endtask

  // Waits until every byte has been taken and every result has arrived, then
  // lets the parser finish any byte that causes no result.
  task automatic settle();
    do @(posedge clk);
    while (comp_bytes_q.size() > 0 || in_ch.valid || decoded_q.size() > 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [12:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    dec_capacity = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_bytes(input logic [7:0] b[], input logic close);
    foreach (b[i]) push_byte(b[i], close && i == b.size() - 1);
    flush_block();
  endtask

  initial begin
    cfg_we <= 1'b0;
    cfg_data <= 13'd0;
    dec_capacity = 4096;
    clear_block();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: an empty block, an overlapping match with a length extension,
    // a zero offset, an offset reaching past the output, and truncation at a
    // token that calls for a length extension and inside the literals.
    queue_bytes('{8'h00}, 1'b1);
    queue_bytes('{8'h1F, 8'h41, 8'h01, 8'h00, 8'h05, 8'h10, 8'hFF}, 1'b1);
    queue_bytes('{8'h10, 8'h55, 8'h00, 8'h00, 8'hFF}, 1'b1);
    queue_bytes('{8'h20, 8'h01, 8'h02, 8'h05, 8'h00, 8'h00}, 1'b1);
    queue_bytes('{8'hF0}, 1'b1);
    queue_bytes('{8'h30, 8'h11}, 1'b1);
    random_stretch(70);
    settle();

    // A capacity of one byte: almost every block ends in an error.
    set_capacity(13'd1);
    random_stretch(50);
    settle();

    // The largest register value, capped at the history size. The literal
    // length runs past the top of its range and saturates.
    set_capacity(13'd8191);
    push_byte(8'hF0, 1'b0);
    repeat (33) push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    flush_block();
    random_stretch(60);
    settle();

    set_capacity(13'($urandom_range(20, 300)));
    random_stretch(60);
    settle();

    // Last part of the run with no idling on either side.
    set_capacity(13'd4096);
    calm = 1'b1;
    random_stretch(60);
    settle();

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/lz4d_pkg.sv
rtl/lz4d_stream_if.sv
rtl/lz4d_parser.sv
rtl/lz4d_copier.sv
rtl/lz4_block_decompressor.sv
tb/lz4_block_decompressor_tb.sv
